### rtl/iiel_pkg.sv
// Shared constants and types for the indexed insert/erase list.
`default_nettype none

package iiel_pkg;

    // Default number of list entries
    localparam int CAPACITY_DEF = 16;

    // Payload widths fixed by the request and response formats
    localparam int OP_W    = 3;
    localparam int INDEX_W = 5;
    localparam int WORD_W  = 32;
    localparam int FILL_W  = 5;
    localparam int STAT_W  = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OP_W-1:0] OP_DROP   = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Broadcast control from the list controller to every cell
    typedef struct packed {
        logic                     do_append;
        logic                     do_insert;
        logic                     do_erase;
        logic signed [WORD_W-1:0] value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/iiel_req_if.sv
// Request channel: operation, position and word, with valid/ready handshake.
`default_nettype none

interface iiel_req_if;

    logic                                      valid;
    logic                                      ready;
    logic        [iiel_pkg::OP_W-1:0]          op;
    logic        [iiel_pkg::INDEX_W-1:0]       index;
    logic signed [iiel_pkg::WORD_W-1:0]        value;

    modport source (output valid, output op, output index, output value, input ready);
    modport sink   (input valid, input op, input index, input value, output ready);

endinterface

`default_nettype wire

### rtl/iiel_rsp_if.sv
// Response channel: word read, fill level and status, with valid/ready handshake.
`default_nettype none

interface iiel_rsp_if;

    logic                                      valid;
    logic                                      ready;
    logic signed [iiel_pkg::WORD_W-1:0]        read_value;
    logic        [iiel_pkg::FILL_W-1:0]        fill_level;
    logic        [iiel_pkg::STAT_W-1:0]        status;

    modport source (output valid, output read_value, output fill_level, output status,
                    input ready);
    modport sink   (input valid, input read_value, input fill_level, input status,
                    output ready);

endinterface

`default_nettype wire

### rtl/iiel_cell.sv
// One list entry: holds a word and loads, shifts up or shifts down as commanded.
`default_nettype none

module iiel_cell #(
    parameter int POS   = 0,
    parameter int CNT_W = 5
) (
    input  wire                                  clk,
    input  wire iiel_pkg::cell_ctrl_t            ctrl,
    input  wire        [CNT_W-1:0]               index,
    input  wire        [CNT_W-1:0]               count,
    input  wire signed [iiel_pkg::WORD_W-1:0]    left_data,
    input  wire signed [iiel_pkg::WORD_W-1:0]    right_data,
    output logic signed [iiel_pkg::WORD_W-1:0]   data,
    output logic signed [iiel_pkg::WORD_W-1:0]   read_part
);

    localparam logic [CNT_W-1:0] POS_V = CNT_W'(POS);

    logic signed [iiel_pkg::WORD_W-1:0] data_reg;
    logic signed [iiel_pkg::WORD_W-1:0] data_next;

    // Pick the next word: load, take from the lower neighbor, take from the upper one, or hold
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.do_append && (POS_V == count))
        begin
            data_next = ctrl.value;
        end
        else if (ctrl.do_insert && (POS_V == index))
        begin
            data_next = ctrl.value;
        end
        else if (ctrl.do_insert && (POS_V > index))
        begin
            data_next = left_data;
        end
        else if (ctrl.do_erase && (POS_V >= index))
        begin
            data_next = right_data;
        end
    end

    // Hold the word
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // Drive this entry onto the read bus when addressed
    assign data      = data_reg;
    assign read_part = (POS_V == index) ? data_reg : '0;

endmodule

`default_nettype wire

### rtl/indexed_insert_erase_list.sv
// Indexed insert/erase list: ordered list of signed words kept in a chain of cells.
//
// Usage: requests arrive on req (op, index, value) and every accepted request
// produces exactly one response on rsp (read_value, fill_level, status).
// Operations: append, drop last, insert at index, erase at index, read at
// index, clear. Insert and erase move every later entry one place at once,
// since each cell takes its word from its neighbor in parallel.
// The response is registered and shows in the cycle after acceptance.
// Throughput: one request per cycle while responses are taken; the whole
// operation, including the shift across the chain, completes in the accepting cycle.
// The read path is an OR of all cells gated by their position match.
// Stall: while a response waits and rsp.ready is low, req.ready is low; the
// response register frees up in the cycle it is taken, so a new request is
// accepted in that same cycle.
// Reset: rst_n clears the element count and the response valid; stored words
// are not cleared and cannot be read until written again.
`default_nettype none

module indexed_insert_erase_list #(
    parameter int CAPACITY = iiel_pkg::CAPACITY_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    iiel_req_if.sink   req,
    iiel_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > iiel_pkg::INDEX_W) ? CNT_W : iiel_pkg::INDEX_W;
    localparam int WW    = iiel_pkg::WORD_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                                 rsp_valid_reg;
    logic signed [WW-1:0]                 rsp_read_value_reg;
    logic [iiel_pkg::FILL_W-1:0]          rsp_fill_level_reg;
    logic [iiel_pkg::STAT_W-1:0]          rsp_status_reg;

    logic                                 accept;
    logic [CMP_W-1:0]                     idx_w;
    logic [CMP_W-1:0]                     cnt_w;
    logic                                 is_full;
    logic                                 idx_le_cnt;
    logic                                 idx_lt_cnt;
    logic                                 append_en;
    logic                                 insert_en;
    logic                                 erase_en;
    logic                                 read_en;
    logic [iiel_pkg::STAT_W-1:0]          status_next;
    iiel_pkg::cell_ctrl_t                 ctrl;
    logic [CNT_W-1:0]                     cell_index;

    logic signed [WW-1:0] cell_data [CAPACITY];
    logic signed [WW-1:0] read_part [CAPACITY];
    logic signed [WW-1:0] read_bus;

    // Take a request whenever the response register is empty or being drained
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // Compare position and count at a common width
    assign idx_w      = CMP_W'(req.index);
    assign cnt_w      = CMP_W'(count_reg);
    assign is_full    = (cnt_w >= CMP_W'(CAPACITY));
    assign idx_le_cnt = (idx_w <= cnt_w);
    assign idx_lt_cnt = (idx_w < cnt_w);

    // Decode the operation into cell commands, next count and status
    always_comb
    begin
        append_en   = 1'b0;
        insert_en   = 1'b0;
        erase_en    = 1'b0;
        read_en     = 1'b0;
        count_next  = count_reg;
        status_next = iiel_pkg::ST_OK;
        case (req.op)
            iiel_pkg::OP_APPEND:
            begin
                if (is_full)
                begin
                    status_next = iiel_pkg::ST_FULL;
                end
                else
                begin
                    append_en  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            iiel_pkg::OP_DROP:
            begin
                if (count_reg == '0)
                begin
                    status_next = iiel_pkg::ST_RANGE;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            iiel_pkg::OP_INSERT:
            begin
                if (!idx_le_cnt)
                begin
                    status_next = iiel_pkg::ST_RANGE;
                end
                else if (is_full)
                begin
                    status_next = iiel_pkg::ST_FULL;
                end
                else
                begin
                    insert_en  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            iiel_pkg::OP_ERASE:
            begin
                if (!idx_lt_cnt)
                begin
                    status_next = iiel_pkg::ST_RANGE;
                end
                else
                begin
                    erase_en   = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            iiel_pkg::OP_READ:
            begin
                if (!idx_lt_cnt)
                begin
                    status_next = iiel_pkg::ST_RANGE;
                end
                else
                begin
                    read_en = 1'b1;
                end
            end
            iiel_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Broadcast commands to the chain, only for an accepted request
    always_comb
    begin
        ctrl.do_append = accept && append_en;
        ctrl.do_insert = accept && insert_en;
        ctrl.do_erase  = accept && erase_en;
        ctrl.value     = req.value;
    end

    // Index fits the count width whenever an operation uses it
    assign cell_index = CNT_W'(idx_w);

    // Build the chain of cells
    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [WW-1:0] left_data;
        logic signed [WW-1:0] right_data;

        if (k == 0)
        begin : g_first
            assign left_data = cell_data[k];
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[k];
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[k+1];
        end

        iiel_cell #(
            .POS   (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .index      (cell_index),
            .count      (count_reg),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[k]),
            .read_part  (read_part[k])
        );
    end

    // Combine the addressed cell onto the read bus
    always_comb
    begin
        read_bus = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            read_bus = read_bus | read_part[k];
        end
    end

    // Advance the element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // Hold the response valid until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Capture the response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_read_value_reg <= read_en ? read_bus : '0;
            rsp_fill_level_reg <= iiel_pkg::FILL_W'(count_next);
            rsp_status_reg     <= status_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_read_value_reg;
    assign rsp.fill_level = rsp_fill_level_reg;
    assign rsp.status     = rsp_status_reg;

endmodule

`default_nettype wire

### bench/indexed_insert_erase_list_tb.sv
// Self-checking bench for the indexed insert/erase list: directed and random requests.
module indexed_insert_erase_list_tb;

    localparam int CAP         = iiel_pkg::CAPACITY_DEF;
    localparam int RANDOM_REQS = 400;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;
    localparam int HOLD_CYCLES = 90;
    localparam int IDLE_PCT    = 38;

    // Op codes the block has no use for
    localparam logic [iiel_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [iiel_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic        [iiel_pkg::OP_W-1:0]    op;
        logic        [iiel_pkg::INDEX_W-1:0] index;
        logic signed [iiel_pkg::WORD_W-1:0]  value;
        bit                                  drain_first;
    } list_req_t;

    typedef struct {
        logic signed [iiel_pkg::WORD_W-1:0] read_value;
        logic        [iiel_pkg::FILL_W-1:0] fill_level;
        logic        [iiel_pkg::STAT_W-1:0] status;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    iiel_req_if req_ch ();
    iiel_rsp_if rsp_ch ();

    indexed_insert_erase_list #(
        .CAPACITY (CAP)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Pending requests, and responses the list should still return
    list_req_t stim_q[$];
    list_rsp_t expected_rsp_q[$];

    // Shadow list state
    logic signed [iiel_pkg::WORD_W-1:0] shadow_words [CAP];
    int                                 shadow_len;

    // Length as seen by the stimulus builder, used to aim indexes
    int gen_len;

    int n_sent;
    int n_done;
    int n_errors;
    int quiet_cycles;
    int hold_left;
    bit hold_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Apply one request to the shadow list and return its response
    function automatic list_rsp_t apply_list_op(input list_req_t r);
        list_rsp_t res;
        int        k;
        res.read_value = '0;
        res.status     = iiel_pkg::ST_OK;
        case (r.op)
            iiel_pkg::OP_APPEND:
                if (shadow_len >= CAP)
                begin
                    res.status = iiel_pkg::ST_FULL;
                end
                else
                begin
                    shadow_words[shadow_len] = r.value;
                    shadow_len++;
                end
            iiel_pkg::OP_DROP:
                if (shadow_len == 0) res.status = iiel_pkg::ST_RANGE;
                else shadow_len--;
            iiel_pkg::OP_INSERT:
                if (int'(r.index) > shadow_len)
                begin
                    res.status = iiel_pkg::ST_RANGE;
                end
                else if (shadow_len >= CAP)
                begin
                    res.status = iiel_pkg::ST_FULL;
                end
                else
                begin
                    for (k = shadow_len; k > int'(r.index); k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[r.index] = r.value;
                    shadow_len++;
                end
            iiel_pkg::OP_ERASE:
                if (int'(r.index) >= shadow_len)
                begin
                    res.status = iiel_pkg::ST_RANGE;
                end
                else
                begin
                    for (k = r.index; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                end
            iiel_pkg::OP_READ:
                if (int'(r.index) >= shadow_len) res.status = iiel_pkg::ST_RANGE;
                else res.read_value = shadow_words[r.index];
            iiel_pkg::OP_CLEAR:
                shadow_len = 0;
            default: ;
        endcase
        res.fill_level = iiel_pkg::FILL_W'(shadow_len);
        return res;
    endfunction

    // Random word, biased toward the extremes
    function automatic logic signed [iiel_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Queue a request and track the length it leads to
    task automatic queue_op(input logic [iiel_pkg::OP_W-1:0] op, input int idx,
                            input logic signed [iiel_pkg::WORD_W-1:0] val);
        list_req_t r;
        r.op          = op;
        r.index       = iiel_pkg::INDEX_W'(idx);
        r.value       = val;
        r.drain_first = 1'b0;
        stim_q.insert(stim_q.size(), r);
        case (op)
            iiel_pkg::OP_APPEND: if (gen_len < CAP) gen_len++;
            iiel_pkg::OP_DROP:   if (gen_len > 0) gen_len--;
            iiel_pkg::OP_INSERT: if (idx <= gen_len && gen_len < CAP) gen_len++;
            iiel_pkg::OP_ERASE:  if (idx < gen_len) gen_len--;
            iiel_pkg::OP_CLEAR:  gen_len = 0;
            default: ;
        endcase
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            n_sent       <= 0;
        end
        else
        begin : drive_req
            list_req_t nxt;
            int        accepted;
            bit        calm;
            accepted = n_sent + ((req_ch.valid && req_ch.ready) ? 1 : 0);
            calm     = (accepted >= 220 && accepted < 320);
            n_sent <= accepted;
            if (!req_ch.valid || req_ch.ready)
            begin
                // hold a draining request until every response is back
                if (stim_q.size() != 0 && !(stim_q[0].drain_first && n_done != accepted)
                    && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt = stim_q.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.op    <= nxt.op;
                    req_ch.index <= nxt.index;
                    req_ch.value <= nxt.value;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Response ready: random stalls, one long hold-off, one calm stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (!hold_done && n_done >= 120)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end
        else if (n_done >= 220 && n_done < 320)
        begin
            rsp_ch.ready <= 1'b1;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Predict on accepted requests, compare accepted responses
    always @(posedge clk)
    begin
        if (rst_n)
        begin : watch_list
            list_req_t r;
            list_rsp_t want;
            list_rsp_t got_pred;
            if (req_ch.valid && req_ch.ready)
            begin
                r.op          = req_ch.op;
                r.index       = req_ch.index;
                r.value       = req_ch.value;
                r.drain_first = 1'b0;
                got_pred      = apply_list_op(r);
                expected_rsp_q.insert(expected_rsp_q.size(), got_pred);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_done <= n_done + 1;
                if (expected_rsp_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected response read_value=%0d fill_level=%0d status=%0d",
                             $time, rsp_ch.read_value, rsp_ch.fill_level, rsp_ch.status);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp_ch.read_value !== want.read_value)
                    begin
                        n_errors++;
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, rsp_ch.read_value);
                    end
                    if (rsp_ch.fill_level !== want.fill_level)
                    begin
                        n_errors++;
                        $display("%0t: fill_level expected %0d actual %0d",
                                 $time, want.fill_level, rsp_ch.fill_level);
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        n_errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_ch.status);
                    end
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin : stimulus
        int n_directed;
        int total_reqs;
        int n_mix;
        int pick;
        int i;

        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = iiel_pkg::OP_APPEND;
        req_ch.index = '0;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        n_errors     = 0;
        n_done       = 0;
        quiet_cycles = 0;
        shadow_len   = 0;
        gen_len      = 0;
        for (i = 0; i < CAP; i++) shadow_words[i] = '0;

        // Directed: empty list, extremes, middle and end positions, spare ops
        queue_op(iiel_pkg::OP_READ,   0,  '0);
        queue_op(iiel_pkg::OP_DROP,   0,  '0);
        queue_op(iiel_pkg::OP_ERASE,  0,  '0);
        queue_op(iiel_pkg::OP_INSERT, 1,  32'sh1234_5678);
        queue_op(iiel_pkg::OP_INSERT, 0,  32'sh7FFF_FFFF);
        queue_op(iiel_pkg::OP_APPEND, 0,  32'sh8000_0000);
        queue_op(iiel_pkg::OP_INSERT, 1,  '0);
        queue_op(iiel_pkg::OP_INSERT, 3,  -32'sd1);
        for (i = 0; i < 4; i++) queue_op(iiel_pkg::OP_READ, i, '0);
        queue_op(iiel_pkg::OP_READ,   4,  '0);
        queue_op(iiel_pkg::OP_READ,   31, '0);
        queue_op(iiel_pkg::OP_ERASE,  1,  '0);
        queue_op(iiel_pkg::OP_ERASE,  2,  '0);
        queue_op(iiel_pkg::OP_ERASE,  31, '0);
        queue_op(OP_SPARE_6, 31, -32'sd1);
        queue_op(OP_SPARE_7, 0,  '0);
        queue_op(iiel_pkg::OP_DROP,   0,  '0);
        queue_op(iiel_pkg::OP_READ,   0,  '0);
        queue_op(iiel_pkg::OP_CLEAR,  0,  '0);
        queue_op(iiel_pkg::OP_READ,   0,  '0);
        stim_q[stim_q.size()-1].drain_first = 1'b1;
        n_directed = stim_q.size();

        // Random bursts: fill to full, drain to empty, or mixed traffic
        while (stim_q.size() < n_directed + RANDOM_REQS)
        begin
            pick = $urandom_range(9);
            if (pick <= 2)
            begin
                while (gen_len < CAP)
                begin
                    if ($urandom_range(1))
                        queue_op(iiel_pkg::OP_APPEND, $urandom_range(31), rand_word());
                    else
                        queue_op(iiel_pkg::OP_INSERT, $urandom_range(gen_len), rand_word());
                end
                queue_op(iiel_pkg::OP_APPEND, 0, rand_word());
                queue_op(iiel_pkg::OP_INSERT, $urandom_range(CAP), rand_word());
                queue_op(iiel_pkg::OP_INSERT, $urandom_range(31, CAP + 1), rand_word());
                repeat (3) queue_op(iiel_pkg::OP_READ, $urandom_range(CAP - 1), '0);
            end
            else if (pick <= 4)
            begin
                while (gen_len > 0)
                begin
                    case ($urandom_range(3))
                        0:       queue_op(iiel_pkg::OP_DROP, $urandom_range(31), rand_word());
                        1:       queue_op(iiel_pkg::OP_READ, $urandom_range(gen_len - 1), '0);
                        default: queue_op(iiel_pkg::OP_ERASE, $urandom_range(gen_len - 1),
                                          rand_word());
                    endcase
                end
                if ($urandom_range(1)) queue_op(iiel_pkg::OP_DROP, 0, '0);
                else queue_op(iiel_pkg::OP_ERASE, $urandom_range(31), '0);
            end
            else if (pick <= 8)
            begin
                n_mix = $urandom_range(20, 8);
                repeat (n_mix)
                begin
                    i = ($urandom_range(4) == 0) ? $urandom_range(31)
                                                 : $urandom_range(gen_len);
                    pick = $urandom_range(99);
                    if (pick < 20)      queue_op(iiel_pkg::OP_APPEND, i, rand_word());
                    else if (pick < 30) queue_op(iiel_pkg::OP_DROP, i, rand_word());
                    else if (pick < 50) queue_op(iiel_pkg::OP_INSERT, i, rand_word());
                    else if (pick < 65) queue_op(iiel_pkg::OP_ERASE, i, rand_word());
                    else if (pick < 90) queue_op(iiel_pkg::OP_READ, i, rand_word());
                    else if (pick < 95) queue_op(iiel_pkg::OP_CLEAR, i, rand_word());
                    else if (pick < 98) queue_op(OP_SPARE_6, i, rand_word());
                    else                queue_op(OP_SPARE_7, i, rand_word());
                end
            end
            else
            begin
                queue_op(iiel_pkg::OP_CLEAR, $urandom_range(31), rand_word());
                queue_op(iiel_pkg::OP_READ, $urandom_range(31), rand_word());
            end
        end
        // Pause the sender once more in the middle of the random part
        stim_q[n_directed + 280].drain_first = 1'b1;
        total_reqs = stim_q.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to go out and every response to come back
        while (!(n_sent == total_reqs && n_done == n_sent)) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_rsp_q.size() != 0)
        begin
            n_errors++;
            $display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
        end
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
rtl/iiel_pkg.sv
rtl/iiel_req_if.sv
rtl/iiel_rsp_if.sv
rtl/iiel_cell.sv
rtl/indexed_insert_erase_list.sv
bench/indexed_insert_erase_list_tb.sv
